[rtl/core/gwm_pkg.sv]
// Glob wildcard matcher: shared widths, character codes, register indexes,
// the cell control and neighbor link structs, and the ASCII case fold.
// No dependencies.
package gwm_pkg;

  localparam int unsigned TEXT_W          = 8;
  localparam int unsigned LEN_W           = 6;
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned BYTES_PER_WORD  = 8;
  localparam int unsigned MAX_PATTERN_DEF = 32;

  localparam logic [TEXT_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [TEXT_W-1:0] CHAR_QUEST = 8'h3F;
  localparam logic [TEXT_W-1:0] CHAR_LO_A  = 8'h61;
  localparam logic [TEXT_W-1:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [TEXT_W-1:0] CASE_DIST  = 8'h20;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PAT0 = 3'd0,
    REG_PAT1 = 3'd1,
    REG_PAT2 = 3'd2,
    REG_PAT3 = 3'd3,
    REG_LEN  = 3'd4,
    REG_CASE = 3'd5
  } cfg_reg_e;

  // Per-item control broadcast to every cell.
  typedef struct packed {
    logic advance;
    logic at_start;
    logic present;
    logic case_blind;
  } cell_ctrl_t;

  // Bits handed from cell i to cell i+1.
  typedef struct packed {
    logic shift;  // character consumed at position i, lands on i+1
    logic carry;  // closure over a star at position i
    logic prime;  // primed set bit for the next position
  } link_t;

  function automatic logic [TEXT_W-1:0] fold_upper(input logic [TEXT_W-1:0] c,
                                                   input logic en);
    logic [TEXT_W-1:0] r;
    r = c;
    if (en && c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      r = c - CASE_DIST;
    end
    return r;
  endfunction

endpackage

[rtl/core/gwm_cell.sv]
// One pattern position of the glob matcher chain: holds the pattern byte and
// the reachable bit for its position, links to its right neighbor.
// Depends on gwm_pkg.
module gwm_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gwm_pkg::cell_ctrl_t        ctrl_i,
  input  logic [gwm_pkg::TEXT_W-1:0] text_i,
  input  logic                       pat_we_i,
  input  logic [gwm_pkg::TEXT_W-1:0] pat_byte_i,
  input  logic                       act_i,
  input  logic                       live_i,
  input  gwm_pkg::link_t             link_i,
  output gwm_pkg::link_t             link_o,
  output logic                       after_o
);
  import gwm_pkg::*;

  logic [TEXT_W-1:0] pat_q, pat_d;
  logic              r_q, r_d;
  logic              is_star, hit, set_bit, nxt, clo;

  always_comb begin
    is_star = (pat_q == CHAR_STAR);
    hit     = (pat_q == CHAR_QUEST) || (fold_upper(pat_q, ctrl_i.case_blind) == text_i);
    set_bit = (ctrl_i.at_start ? link_i.prime : r_q) & live_i;
    nxt     = (set_bit & is_star & act_i) | link_i.shift;
    clo     = nxt | link_i.carry;
    after_o = ctrl_i.present ? clo : set_bit;

    link_o.shift = set_bit & act_i & ~is_star & hit;
    link_o.carry = clo & is_star & act_i;
    link_o.prime = link_i.prime & is_star & act_i;

    pat_d = pat_we_i ? pat_byte_i : pat_q;
    r_d   = ctrl_i.advance ? after_o : r_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      r_q   <= 1'b0;
    end else begin
      pat_q <= pat_d;
      r_q   <= r_d;
    end
  end

endmodule

[rtl/core/glob_wildcard_matcher_unit.sv]
// Glob wildcard matcher top level: configuration registers, the row of
// pattern cells, the last-position bit and the registered result stage.
// Depends on gwm_pkg and gwm_cell.

// Streams test strings one byte per request and matches each string against
// a glob pattern of up to MAX_PATTERN bytes ('*' = any run, '?' = any one
// character, anything else literal; case_blind folds a-z to upper case).
// Each pattern position is a cell holding its byte and one reachable bit;
// the set of reachable positions moves through the row as the bytes arrive,
// with the star closure rippling from cell to cell like a carry chain. One
// request is taken every cycle unless stalled, including the cycle after a
// string end, and the result is registered in the cycle after the request
// that closes the string (tlast); only string-end requests produce a result.
// An empty string is a single tlast request with tuser bit 0 clear. A request
// with neither a character nor tlast is consumed and ignored. The input is
// stalled only while a result sits in the output register and the master side
// holds tready low. Write the configuration only while the block is idle.
module glob_wildcard_matcher_unit #(
  parameter int unsigned MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [gwm_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [gwm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input stream
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [7:0]                     s_tdata_i,   // [7:0] text_byte
  input  logic                           s_tuser_i,   // [0] byte_present
  input  logic                           s_tlast_i,   // string_end
  // result stream
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [7:0]                     m_tdata_o    // [0] matched, [7:1] zero
);
  import gwm_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_PATTERN + 1);

  // configuration
  logic [LEN_W-1:0] len_q, len_d;
  logic             cb_q, cb_d;
  logic [LEN_W-1:0] used_len;

  // handshake and item control
  logic       s_acc, advance, at_start_q, at_start_d;
  cell_ctrl_t ctrl;
  logic [TEXT_W-1:0] text_folded;

  // chain
  link_t              lk [MAX_PATTERN+1];
  logic [MAX_PATTERN:0] after;
  logic r_last_q, r_last_d, set_last, clo_last;

  // output stage
  logic m_valid_q, m_valid_d, m_bit_q, m_bit_d;

  always_comb begin
    len_d = len_q;
    cb_d  = cb_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_LEN:  len_d = cfg_wdata_i[LEN_W-1:0];
        REG_CASE: cb_d  = cfg_wdata_i[0];
        default:  ;  // pattern words load inside the cells
      endcase
    end
    // saturate the length to the number of cells
    used_len = (len_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_q;
  end

  assign s_tready_o  = ~m_valid_q | m_tready_i;
  assign s_acc       = s_tvalid_i & s_tready_o;
  // drop requests that carry neither a character nor an end mark
  assign advance     = s_acc & (s_tuser_i | s_tlast_i);
  assign text_folded = fold_upper(s_tdata_i, cb_q);

  always_comb begin
    ctrl.advance    = advance;
    ctrl.at_start   = at_start_q;
    ctrl.present    = s_tuser_i;
    ctrl.case_blind = cb_q;
  end

  // position 0 is always in the primed set
  assign lk[0] = '{shift: 1'b0, carry: 1'b0, prime: 1'b1};

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic pat_we;
    assign pat_we = cfg_we_i &&
                    (cfg_addr_i == (CFG_ADDR_W'(REG_PAT0) + CFG_ADDR_W'(i / BYTES_PER_WORD)));
    gwm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .text_i     (text_folded),
      .pat_we_i   (pat_we),
      .pat_byte_i (cfg_wdata_i[(i % BYTES_PER_WORD) * TEXT_W +: TEXT_W]),
      .act_i      (LEN_W'(i) < used_len),
      .live_i     (LEN_W'(i) <= used_len),
      .link_i     (lk[i]),
      .link_o     (lk[i+1]),
      .after_o    (after[i])
    );
  end

  // final position: only reached by transitions, never consumes
  always_comb begin
    set_last = (at_start_q ? lk[MAX_PATTERN].prime : r_last_q) &
               (used_len == LEN_W'(MAX_PATTERN));
    clo_last = lk[MAX_PATTERN].shift | lk[MAX_PATTERN].carry;
  end

  assign after[MAX_PATTERN] = s_tuser_i ? clo_last : set_last;
  assign r_last_d           = advance ? after[MAX_PATTERN] : r_last_q;

  // re-prime after every string end
  assign at_start_d = advance ? s_tlast_i : at_start_q;

  always_comb begin
    m_valid_d = m_valid_q;
    m_bit_d   = m_bit_q;
    if (advance && s_tlast_i) begin
      m_valid_d = 1'b1;
      m_bit_d   = after[used_len[IdxW-1:0]];
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      cb_q       <= 1'b0;
      at_start_q <= 1'b1;
      r_last_q   <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      len_q      <= len_d;
      cb_q       <= cb_d;
      at_start_q <= at_start_d;
      r_last_q   <= r_last_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_bit_q <= m_bit_d;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {7'b0, m_bit_q};

endmodule

[rtl/core/gwm_checker.sv]
// Port-level checks for the glob wildcard matcher, bound to the top level.
// Depends on glob_wildcard_matcher_unit (bind target).
module gwm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_tvalid_i,
  input logic       s_tready_o,
  input logic       s_tlast_i,
  input logic       m_tvalid_o,
  input logic       m_tready_i,
  input logic [7:0] m_tdata_o
);

  logic s_acc;
  assign s_acc = s_tvalid_i & s_tready_o;

  // a string end request yields a result in the next cycle
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_tlast_i |=> m_tvalid_o)
    else $error("no result after string end request");

  // no result appears without a string end request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_tvalid_o || m_tready_i) && !(s_acc && s_tlast_i) |=> !m_tvalid_o)
    else $error("result without string end request");

  // an empty output register never stalls the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid_o |-> s_tready_o)
    else $error("input stalled with empty output");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("result dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> $stable(m_tdata_o))
    else $error("result changed while stalled");

endmodule

bind glob_wildcard_matcher_unit gwm_checker u_gwm_checker (.*);
